FILE: src/lpr_pkg.sv
// Shared constants and types for the LRU page replacement core.
package lpr_pkg;

  // Default geometry of the frame table.
  localparam int FRAMES_DEF    = 8;
  localparam int PAGE_BITS_DEF = 16;

  // Fixed field widths.
  localparam int CAP_W   = 4;
  localparam int FAULT_W = 32;

  // Capacity after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

  // Control word broadcast from the sequencer to every frame cell.
  typedef struct packed {
    logic look;   // compare the broadcast page against the stored page
    logic upd;    // apply the table update for the current request
    logic hit;    // the request hit a resident page
    logic evict;  // the request misses and replaces the LRU page
  } lpr_cmd_t;

endpackage

FILE: src/lpr_cell.sv
// One frame of the LRU table: page tag, valid bit, age rank and chain links.
module lpr_cell #(
  parameter int PAGE_BITS = lpr_pkg::PAGE_BITS_DEF,
  parameter int AGE_W     = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lpr_pkg::lpr_cmd_t    cmd,
  input  logic [PAGE_BITS-1:0] page,
  input  logic [AGE_W-1:0]     found_age,
  input  logic [AGE_W-1:0]     victim_age,
  input  logic                 hit_in,
  input  logic [AGE_W-1:0]     age_in,
  input  logic                 free_in,
  input  logic [PAGE_BITS-1:0] evpage_in,
  output logic                 hit_out,
  output logic [AGE_W-1:0]     age_out,
  output logic                 free_out,
  output logic [PAGE_BITS-1:0] evpage_out
);
  import lpr_pkg::*;

  logic                 valid_r, valid_nxt;
  logic [AGE_W-1:0]     age_r, age_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic                 match_r, match_nxt;
  logic                 victim;
  logic                 claim;

  // The oldest resident frame holds the highest rank.
  assign victim = valid_r && (age_r == victim_age);
  // The first empty frame along the chain takes a new page.
  assign claim  = !valid_r && !free_in;

  // Chain links toward the next cell.
  assign hit_out    = hit_in | match_r;
  assign age_out    = age_in | (match_r ? age_r : '0);
  assign free_out   = free_in | !valid_r;
  assign evpage_out = evpage_in | (victim ? page_r : '0);

  // Next state of this frame.
  always_comb begin
    valid_nxt = valid_r;
    age_nxt   = age_r;
    page_nxt  = page_r;
    match_nxt = match_r;
    if (cmd.look) begin
      match_nxt = valid_r && (page_r == page);
    end
    if (cmd.upd) begin
      if (cmd.hit) begin
        if (match_r) begin
          age_nxt = '0;
        end else if (valid_r && (age_r < found_age)) begin
          age_nxt = age_r + AGE_W'(1);
        end
      end else if (cmd.evict) begin
        if (victim) begin
          page_nxt = page;
          age_nxt  = '0;
        end else if (valid_r) begin
          age_nxt = age_r + AGE_W'(1);
        end
      end else begin
        if (claim) begin
          valid_nxt = 1'b1;
          page_nxt  = page;
          age_nxt   = '0;
        end else if (valid_r) begin
          age_nxt = age_r + AGE_W'(1);
        end
      end
    end
  end

  // Frame registers; the page tag needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      age_r   <= '0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      age_r   <= age_nxt;
      match_r <= match_nxt;
    end
    page_r <= page_nxt;
  end

endmodule

FILE: src/lru_page_replacement_core.sv
// Top level of the LRU page replacement core: request sequencer and a chain of frame cells.
// Each request carries one page number and produces one result: hit flag, eviction flag,
// evicted page and the running saturating fault count. Each request passes the sequencer
// steps accept, associative compare in every frame cell and table update, and the next
// is taken only after that update; a new request is accepted while the previous result still
// waits in the output register, and only the update step waits for that register to empty.
// The frame table holds FRAMES cells, each with a page tag, a valid bit and an age rank;
// rank 0 is the most recently used page. The capacity register limits how many frames are
// used (zero acts as one, values above FRAMES act as FRAMES) and should be written only
// while no request is in flight.
module lru_page_replacement_core #(
  parameter int FRAMES    = lpr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lpr_pkg::PAGE_BITS_DEF,
  localparam int IN_W     = ((PAGE_BITS + 7) / 8) * 8,
  localparam int OUT_W    = ((2 + PAGE_BITS + lpr_pkg::FAULT_W + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Request channel.
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [IN_W-1:0]           in_tdata,   // page_number
  // Result channel.
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_W-1:0]          out_tdata,  // hit, evicted_valid, evicted_page, fault_total
  // Capacity register.
  input  logic                      cfg_wen,
  input  logic [lpr_pkg::CAP_W-1:0] cfg_wdata
);
  import lpr_pkg::*;

  localparam int AGE_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W = $clog2(FRAMES + 1);

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_UPD} state_t;

  state_t               state_r, state_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic [CNT_W-1:0]     rc_r, rc_nxt;
  logic [FAULT_W-1:0]   fault_r, fault_nxt;
  logic [CAP_W-1:0]     cap_r, cap_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]     out_data_r, out_data_nxt;

  lpr_cmd_t             cmd;
  logic [CNT_W-1:0]     eff_cap;
  logic [AGE_W-1:0]     victim_age;
  logic                 out_free;

  // Chain links between the cells.
  logic [FRAMES:0]      hit_c;
  logic [FRAMES:0]      free_c;
  logic [AGE_W-1:0]     age_c [FRAMES+1];
  logic [PAGE_BITS-1:0] ev_c  [FRAMES+1];

  assign hit_c[0]  = 1'b0;
  assign free_c[0] = 1'b0;
  assign age_c[0]  = '0;
  assign ev_c[0]   = '0;

  // Row of frame cells.
  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    lpr_cell #(
      .PAGE_BITS (PAGE_BITS),
      .AGE_W     (AGE_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .page       (page_r),
      .found_age  (age_c[FRAMES]),
      .victim_age (victim_age),
      .hit_in     (hit_c[g]),
      .age_in     (age_c[g]),
      .free_in    (free_c[g]),
      .evpage_in  (ev_c[g]),
      .hit_out    (hit_c[g+1]),
      .age_out    (age_c[g+1]),
      .free_out   (free_c[g+1]),
      .evpage_out (ev_c[g+1])
    );
  end

  // Capacity in use: zero acts as one and values above the table size are clamped to it.
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CNT_W'(1);
    end else if (32'(cap_r) > 32'(FRAMES)) begin
      eff_cap = CNT_W'(FRAMES);
    end else begin
      eff_cap = CNT_W'(cap_r);
    end
  end

  // Ranks of resident frames are distinct, so the LRU frame has rank count minus one.
  assign victim_age = AGE_W'(rc_r - CNT_W'(1));

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  // Commands to the cells.
  always_comb begin
    cmd.look  = (state_r == S_LOOK);
    cmd.upd   = (state_r == S_UPD) && out_free;
    cmd.hit   = hit_c[FRAMES];
    cmd.evict = !hit_c[FRAMES] && (rc_r >= eff_cap) && (rc_r != '0);
  end

  // Sequencer, counters and result register.
  always_comb begin
    state_nxt     = state_r;
    page_nxt      = page_r;
    rc_nxt        = rc_r;
    fault_nxt     = fault_r;
    cap_nxt       = cap_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cfg_wen) begin
      cap_nxt = cfg_wdata;
    end
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          page_nxt  = in_tdata[PAGE_BITS-1:0];
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          if (!cmd.hit) begin
            if (fault_r != '1) begin
              fault_nxt = fault_r + FAULT_W'(1);
            end
            if (!cmd.evict) begin
              rc_nxt = rc_r + CNT_W'(1);
            end
          end
          out_data_nxt                          = '0;
          out_data_nxt[0]                       = cmd.hit;
          out_data_nxt[1]                       = cmd.evict;
          out_data_nxt[2 +: PAGE_BITS]          = cmd.evict ? ev_c[FRAMES] : '0;
          out_data_nxt[2+PAGE_BITS +: FAULT_W]  = fault_nxt;
          out_valid_nxt                         = 1'b1;
          state_nxt                             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rc_r        <= '0;
      fault_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rc_r        <= rc_nxt;
      fault_r     <= fault_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
    page_r     <= page_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: src/lpr_checker.sv
// Port-level checks of the LRU page replacement core and their binding.
module lpr_checker #(
  parameter int PAGE_BITS = lpr_pkg::PAGE_BITS_DEF,
  parameter int OUT_W     = ((2 + PAGE_BITS + lpr_pkg::FAULT_W + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);
  import lpr_pkg::*;

  logic                 out_hit;
  logic                 out_evv;
  logic [PAGE_BITS-1:0] out_evpage;
  logic [FAULT_W-1:0]   out_fault;
  logic [FAULT_W-1:0]   prev_fault_r;
  logic                 out_take;

  assign out_hit    = out_tdata[0];
  assign out_evv    = out_tdata[1];
  assign out_evpage = out_tdata[2 +: PAGE_BITS];
  assign out_fault  = out_tdata[2+PAGE_BITS +: FAULT_W];
  assign out_take   = out_tvalid && out_tready;

  // Fault count of the last delivered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_fault_r <= '0;
    end else if (out_take) begin
      prev_fault_r <= out_fault;
    end
  end

  // A held result stays unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // A hit never evicts a page.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_hit |-> !out_evv)
    else $error("eviction reported on a hit");

  // Without an eviction the evicted page field reads zero.
  a_evpage_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_evv |-> out_evpage == '0)
    else $error("evicted page nonzero without eviction");

  // The fault count moves by one on each miss, saturating, and holds on a hit.
  a_fault_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_take |-> (out_hit && out_fault == prev_fault_r) ||
                 (!out_hit && out_fault == prev_fault_r + FAULT_W'(1)) ||
                 (!out_hit && prev_fault_r == '1 && out_fault == '1))
    else $error("fault count out of sequence");

endmodule

bind lru_page_replacement_core lpr_checker #(
  .PAGE_BITS (PAGE_BITS)
) u_lpr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
